// ===== hdl/cpqm_pkg.sv =====
package cpqm_pkg;

  localparam int DW   = 32;
  localparam int FRAC = 16;

  localparam logic signed [63:0] VMAX  = 64'sd2147483647;
  localparam logic signed [63:0] VMIN  = -64'sd2147483648;
  localparam logic signed [63:0] HALF  = 64'sd32768;
  localparam logic signed [63:0] ONE   = 64'sd65536;
  localparam logic signed [63:0] TENTH = 64'sd6554;
  localparam logic signed [63:0] CENT  = 64'sd655;
  localparam logic signed [63:0] HIGH_MARGIN = 64'sd983040;

  localparam logic [23:0] DT_Q   = 24'd83886;
  localparam logic [23:0] POS_KD = 24'd167772;
  localparam logic signed [17:0] THR_STEP  = 18'sd66;
  localparam logic signed [17:0] THR_MAX   = 18'sd32768;
  localparam logic [15:0]        THR_RESET = 16'd21627;

  localparam logic [1:0] MODE_STAB   = 2'd0;
  localparam logic [1:0] MODE_FLIGHT = 2'd1;
  localparam logic [1:0] MODE_LAND   = 2'd2;

  localparam logic [2:0] REG_TX    = 3'd0;
  localparam logic [2:0] REG_TY    = 3'd1;
  localparam logic [2:0] REG_DV    = 3'd2;
  localparam logic [2:0] REG_MODE  = 3'd3;
  localparam logic [2:0] REG_POSKP = 3'd4;
  localparam logic [2:0] REG_KP    = 3'd5;
  localparam logic [2:0] REG_KI    = 3'd6;
  localparam logic [2:0] REG_KD    = 3'd7;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLRSET, OP_ERRP, OP_ERRA, OP_DER, OP_MUL_PKP, OP_MUL_PKD,
    OP_MUL_DT, OP_MUL_KP, OP_MUL_KI, OP_MUL_KD, OP_ADD, OP_INTEG,
    OP_POSOUT, OP_ATTOUT, OP_MOTOR, OP_SQ, OP_TRIM
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
    logic       pos;
    logic       load_in;
    logic       load_out;
  } cmd_t;

  localparam logic [5:0] PROG_LAST = 6'd53;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    return r[31:0];
  endfunction

  function automatic cmd_t prog(input logic [5:0] pc);
    cmd_t c;
    logic [5:0] q;
    c = '0;
    c.op = OP_NOP;
    if (pc == 6'd0) begin
      c.op = OP_CLRSET;
    end else if (pc <= 6'd14) begin
      c.pos = 1'b1;
      c.idx = (pc >= 6'd8) ? 2'd1 : 2'd0;
      q = (pc >= 6'd8) ? pc - 6'd8 : pc - 6'd1;
      case (q)
        6'd0: c.op = OP_ERRP;
        6'd1: c.op = OP_DER;
        6'd2: c.op = OP_MUL_PKP;
        6'd3: c.op = OP_ADD;
        6'd4: c.op = OP_MUL_PKD;
        6'd5: c.op = OP_ADD;
        default: c.op = OP_POSOUT;
      endcase
    end else if (pc <= 6'd47) begin
      if (pc >= 6'd37) begin
        c.idx = 2'd2;
        q = pc - 6'd37;
      end else if (pc >= 6'd26) begin
        c.idx = 2'd1;
        q = pc - 6'd26;
      end else begin
        c.idx = 2'd0;
        q = pc - 6'd15;
      end
      case (q)
        6'd0:  c.op = OP_ERRA;
        6'd1:  c.op = OP_DER;
        6'd2:  c.op = OP_MUL_DT;
        6'd3:  c.op = OP_INTEG;
        6'd4:  c.op = OP_MUL_KP;
        6'd5:  c.op = OP_ADD;
        6'd6:  c.op = OP_MUL_KI;
        6'd7:  c.op = OP_ADD;
        6'd8:  c.op = OP_MUL_KD;
        6'd9:  c.op = OP_ADD;
        default: c.op = OP_ATTOUT;
      endcase
    end else if (pc <= 6'd51) begin
      c.op  = OP_MOTOR;
      q     = pc - 6'd48;
      c.idx = q[1:0];
    end else if (pc == 6'd52) begin
      c.op = OP_SQ;
    end else begin
      c.op = OP_TRIM;
    end
    return c;
  endfunction

endpackage

// ===== hdl/cpqm_ctrl.sv =====
module cpqm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output cpqm_pkg::cmd_t  cmd_o
);
  import cpqm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic [5:0] pc_q, pc_d;
  logic       mv_q, mv_d;
  logic       slot_free;

  assign slot_free     = !mv_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mv_q;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    mv_d    = mv_q && !m_axis_tready;
    cmd_o   = '0;
    cmd_o.op = OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_RUN;
          pc_d    = '0;
        end
      end
      ST_RUN: begin
        cmd_o = prog(pc_q);
        pc_d  = pc_q + 6'd1;
        if (pc_q == PROG_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          mv_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      mv_q    <= mv_d;
    end
  end

endmodule

// ===== hdl/cpqm_dp.sv =====
module cpqm_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpqm_pkg::cmd_t cmd_i,
  input  logic [191:0]   in_data_i,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  output logic [143:0]   out_data_o
);
  import cpqm_pkg::*;

  logic signed [31:0] tx_q, ty_q, dv_q;
  logic [23:0]        poskp_q, kp_q, ki_q, kd_q;
  logic [1:0]         mode_q;
  logic [15:0]        thr_q;
  logic signed [31:0] prevy_q;
  logic signed [31:0] alast_q [3];
  logic signed [31:0] integ_q [3];
  logic signed [31:0] plast_q [2];
  logic signed [31:0] set_q [2];
  logic signed [31:0] drv_q [3];
  logic [10:0]        mot_q [4];
  logic [191:0]       in_q;
  logic signed [31:0] err_q, der_q;
  logic signed [56:0] prod_q;
  logic signed [58:0] acc_q;
  logic [29:0]        sqx_q, sqy_q;
  logic               near_q;
  logic [143:0]       out_q;

  logic signed [31:0] ang, px, py, vy, lastv, setv, mul_a, res;
  logic [23:0]        mul_g;
  logic signed [63:0] dif, dx, dy, adx, ady, sum, cl, pv, dpy, ad, negd;
  logic [27:0]        scaled;
  logic               flying, in_flight, low;
  logic signed [17:0] thr_n;
  logic [2:0]         sgn;

  assign px = in_q[127:96];
  assign py = in_q[159:128];
  assign vy = in_q[191:160];
  assign ang = (cmd_i.idx == 2'd0) ? in_q[31:0] :
               (cmd_i.idx == 2'd1) ? in_q[63:32] : in_q[95:64];
  assign flying    = (mode_q != MODE_STAB);
  assign in_flight = (mode_q == MODE_FLIGHT);
  assign lastv = cmd_i.pos ? plast_q[cmd_i.idx[0]] : alast_q[cmd_i.idx];
  assign setv  = (cmd_i.idx == 2'd2) ? 32'sd0 : set_q[cmd_i.idx[0]];
  assign dif   = 64'(err_q) - 64'(lastv);
  assign res   = sat32(64'(acc_q >>> 24));
  assign dx    = 64'(tx_q) - 64'(px);
  assign dy    = 64'(ty_q) - 64'(py);
  assign adx   = (dx < 0) ? -dx : dx;
  assign ady   = (dy < 0) ? -dy : dy;
  assign dpy   = 64'(prevy_q) - 64'(py);
  assign negd  = -dpy;
  assign ad    = (dpy < 0) ? negd : dpy;
  assign low   = 64'(py) < (64'(ty_q) + HIGH_MARGIN);

  always_comb begin
    case (cmd_i.op)
      OP_MUL_PKP: begin mul_g = poskp_q; mul_a = err_q; end
      OP_MUL_PKD: begin mul_g = POS_KD;  mul_a = der_q; end
      OP_MUL_DT:  begin mul_g = DT_Q;    mul_a = err_q; end
      OP_MUL_KP:  begin mul_g = kp_q;    mul_a = err_q; end
      OP_MUL_KI:  begin mul_g = ki_q;    mul_a = integ_q[cmd_i.idx]; end
      default:    begin mul_g = kd_q;    mul_a = der_q; end
    endcase
  end

  always_comb begin
    case (cmd_i.idx)
      2'd0:    sgn = 3'b011;
      2'd1:    sgn = 3'b101;
      2'd2:    sgn = 3'b110;
      default: sgn = 3'b000;
    endcase
    sum = 64'(thr_q)
        + (sgn[2] ? 64'(drv_q[0]) : -64'(drv_q[0]))
        + (sgn[1] ? 64'(drv_q[1]) : -64'(drv_q[1]))
        + (sgn[0] ? 64'(drv_q[2]) : -64'(drv_q[2]));
    cl = (sum < TENTH) ? TENTH : ((sum > ONE) ? ONE : sum);
    scaled = 28'(cl) * 28'd2000;
    pv = 64'sd1000 + 64'(scaled >> FRAC);
    if (pv > 64'sd2000) pv = 64'sd2000;
  end

  always_comb begin
    thr_n = $signed({2'b00, thr_q});
    if (ad >= CENT) begin
      if (dpy >= 0) begin
        thr_n = (low && in_flight) ? thr_n + THR_STEP : thr_n - THR_STEP;
      end else if (vy > dv_q) begin
        thr_n = (!low && in_flight) ? thr_n + THR_STEP : thr_n - THR_STEP;
      end else if (dv_q > vy) begin
        thr_n = thr_n + THR_STEP;
      end
    end
    if (thr_n < 0) thr_n = '0;
    else if (thr_n > THR_MAX) thr_n = THR_MAX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q    <= 32'sd655360;
      ty_q    <= 32'sd655360;
      dv_q    <= '0;
      poskp_q <= 24'd3355443;
      kp_q    <= 24'd838861;
      ki_q    <= 24'd33554;
      kd_q    <= 24'd16777;
      mode_q  <= MODE_FLIGHT;
      thr_q   <= THR_RESET;
      prevy_q <= '0;
      for (int i = 0; i < 3; i++) begin
        alast_q[i] <= '0;
        integ_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) plast_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TX:    tx_q    <= cfg_data_i;
          REG_TY:    ty_q    <= cfg_data_i;
          REG_DV:    dv_q    <= cfg_data_i;
          REG_MODE:  mode_q  <= {1'b0, cfg_data_i[0]};
          REG_POSKP: poskp_q <= cfg_data_i[23:0];
          REG_KP:    kp_q    <= cfg_data_i[23:0];
          REG_KI:    ki_q    <= cfg_data_i[23:0];
          REG_KD:    kd_q    <= cfg_data_i[23:0];
          default:   ;
        endcase
      end
      case (cmd_i.op)
        OP_DER: begin
          if (cmd_i.pos) begin
            if (flying) plast_q[cmd_i.idx[0]] <= err_q;
          end else begin
            alast_q[cmd_i.idx] <= err_q;
          end
        end
        OP_INTEG: integ_q[cmd_i.idx] <=
          sat32(64'(integ_q[cmd_i.idx]) + 64'(prod_q >>> 24));
        OP_TRIM: begin
          if (flying) begin
            thr_q   <= thr_n[15:0];
            prevy_q <= py;
            if (in_flight && near_q && ({1'b0, sqx_q} + {1'b0, sqy_q} < 31'h40000000))
              mode_q <= MODE_LAND;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
    case (cmd_i.op)
      OP_CLRSET: begin
        set_q[0] <= '0;
        set_q[1] <= '0;
      end
      OP_ERRP: err_q <= sat32((cmd_i.idx[0] ? 64'(ty_q) : 64'(tx_q))
                              - (cmd_i.idx[0] ? 64'(py) : 64'(px)));
      OP_ERRA: err_q <= sat32(64'(setv) - 64'(ang));
      OP_DER: begin
        der_q <= sat32((dif <<< 7) + (dif <<< 6) + (dif <<< 3));
        acc_q <= '0;
      end
      OP_MUL_PKP, OP_MUL_PKD, OP_MUL_DT, OP_MUL_KP, OP_MUL_KI, OP_MUL_KD:
        prod_q <= $signed({1'b0, mul_g}) * mul_a;
      OP_ADD: acc_q <= acc_q + 59'(prod_q);
      OP_POSOUT: begin
        if (flying) begin
          if (cmd_i.idx[0]) begin
            set_q[1] <= (-64'(res) > HALF) ? HALF[31:0] :
                        ((-64'(res) < -HALF) ? 32'(-HALF) : 32'(-64'(res)));
          end else begin
            set_q[0] <= (64'(res) > HALF) ? HALF[31:0] :
                        ((64'(res) < -HALF) ? 32'(-HALF) : res);
          end
        end
      end
      OP_ATTOUT: drv_q[cmd_i.idx] <= res;
      OP_MOTOR:  mot_q[cmd_i.idx] <= pv[10:0];
      OP_SQ: begin
        near_q <= (adx < HALF) && (ady < HALF);
        sqx_q  <= adx[14:0] * adx[14:0];
        sqy_q  <= ady[14:0] * ady[14:0];
      end
      default: ;
    endcase
    if (cmd_i.load_out)
      out_q <= {2'b00, drv_q[2], drv_q[1], drv_q[0], mode_q,
                mot_q[3], mot_q[2], mot_q[1], mot_q[0]};
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/cascaded_pid_quad_mixer.sv =====
// Cascaded PID attitude/position controller with a four-motor mixer.
// Input stream: one transaction per control tick carrying roll, pitch, yaw,
// x, y and y velocity, all signed Q16.16. Output stream: one transaction per
// input with four motor pulse widths (1200..2000), the mode after the tick
// and the three attitude drives.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (target_x, target_y, descent_velocity, start_mode, pos_kp, att_kp,
// att_ki, att_kd); the user writes only while the block is idle, which
// the block itself does not enforce. A sequencer steps one shared 32x25
// multiplier and accumulator through the position, attitude, mixer and
// trim steps. A new input is taken as soon as the previous result has
// been placed in the output register, and not while an item is in work.
// Reset clears the loop state, loads default gains and targets, flight
// mode and thrust 0.33. If the receiver stalls, the result is held and a
// following item waits at the end of its computation.
module cascaded_pid_quad_mixer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, vel_y
  input  logic [191:0]   s_axis_tdata,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // motor_one..motor_four, flight_mode, roll_drive, pitch_drive, yaw_drive
  output logic [143:0]   m_axis_tdata,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);
  import cpqm_pkg::*;

  cmd_t cmd;

  cpqm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  cpqm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule
